@@ design/rce_pkg.sv @@
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types, constants and helper functions for the radio channel effect.
// ----------------------------------------------------------------------------
package rce_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_POST,
    ST_GATE,
    ST_DONE
  } state_e;

  localparam logic [2:0] REG_HP     = 3'd0;
  localparam logic [2:0] REG_LP     = 3'd1;
  localparam logic [2:0] REG_GAIN   = 3'd2;
  localparam logic [2:0] REG_NORM   = 3'd3;
  localparam logic [2:0] REG_THR    = 3'd4;
  localparam logic [2:0] REG_NOISE  = 3'd5;
  localparam logic [2:0] REG_PERIOD = 3'd6;
  localparam logic [2:0] REG_SEED   = 3'd7;

  localparam logic [4:0] STEP_LP_LAST = 5'd7;
  localparam logic [4:0] STEP_HP_LAST = 5'd3;
  localparam logic [4:0] STEP_DRIVE   = 5'd8;
  localparam logic [4:0] STEP_INTERP  = 5'd9;
  localparam logic [4:0] STEP_NORM    = 5'd10;
  localparam logic [4:0] STEP_GOAL    = 5'd12;
  localparam logic [4:0] STEP_GLIDE   = 5'd13;
  localparam logic [4:0] STEP_GATE    = 5'd14;
  localparam logic [4:0] STEP_NOISE   = 5'd15;
  localparam logic [4:0] STEP_MIX     = 5'd16;

  localparam logic [4:0] MUL_LAST = 5'd17;

  function automatic logic [31:0] xs32(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  function automatic logic [15:0] tanh_lut(input logic [5:0] i);
    logic [15:0] r;
    case (i)
      6'd0:  r = 16'd0;
      6'd1:  r = 16'd8025;
      6'd2:  r = 16'd15143;
      6'd3:  r = 16'd20813;
      6'd4:  r = 16'd24956;
      6'd5:  r = 16'd27797;
      6'd6:  r = 16'd29660;
      6'd7:  r = 16'd30847;
      6'd8:  r = 16'd31589;
      6'd9:  r = 16'd32048;
      6'd10: r = 16'd32329;
      6'd11: r = 16'd32500;
      6'd12: r = 16'd32606;
      6'd13: r = 16'd32670;
      6'd14: r = 16'd32708;
      6'd15: r = 16'd32732;
      6'd16: r = 16'd32746;
      6'd17: r = 16'd32755;
      6'd18: r = 16'd32760;
      6'd19: r = 16'd32763;
      6'd20: r = 16'd32765;
      6'd21: r = 16'd32766;
      default: r = 16'd32767;
    endcase
    return r;
  endfunction

endpackage

@@ design/radio_channel_effect.sv @@
// ----------------------------------------------------------------------------
// radio_channel_effect
// Band limiting, soft clipping, random dropout gate and noise for audio.
// ----------------------------------------------------------------------------
// One Q1.15 sample enters per input transaction (sample_in_i, start_flag_i)
// and one Q1.15 sample leaves per output transaction (sample_out_o).
// A transaction completes when valid is high and stall is low.
// All arithmetic runs through one shift-add multiplier that retires one
// multiplier bit per cycle; a sample needs fifteen products, or sixteen
// when a dropout draws a new gate goal. The block takes no new sample
// until the result of the last one has reached the output register.
// The output register lets the next sample enter while a result still
// waits; if the receiver stalls, the finished result of the next sample
// waits inside the block until the register is free.
// Reset loads the register defaults, clears filter history, sets the gate
// to one and loads the generator with one. Configuration writes are taken
// every cycle and must only be issued while the block is idle; a seed
// write also reloads the generator.
// ----------------------------------------------------------------------------
module radio_channel_effect (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sample_in_i,
  input  logic        start_flag_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] sample_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  rce_pkg::state_e state_q, state_d;

  logic [63:0] hp_q, lp_q;
  logic [15:0] gain_q, norm_q, noise_q, period_q, cnt_q;
  logic [24:0] thr_q;
  logic [31:0] rng_q;
  logic signed [23:0] hist_q [8];
  logic signed [23:0] x_q;
  logic [23:0] mag_q;
  logic neg_q;
  logic [16:0] lvl_q, goal_q;
  logic [15:0] base_q;
  logic [12:0] diff_q;
  logic [13:0] frac_q;
  logic signed [16:0] th_q;
  logic signed [20:0] c_q;
  logic signed [25:0] v_q;
  logic signed [41:0] p1_q;
  logic [23:0] draw_q;
  logic [15:0] out_q;
  logic ov_q;
  logic [4:0] step_q, bit_q;
  logic signed [59:0] a_q;
  logic [17:0] b_q;
  logic signed [63:0] acc_q;

  logic signed [41:0] op_a;
  logic [17:0] op_b;
  logic clr_acc;
  logic [63:0] cf;
  logic [15:0] coef;
  logic [2:0] hb;
  logic [31:0] rng_nx, rng_nx2;
  logic signed [17:0] gdiff;
  logic [16:0] half;
  logic signed [59:0] addend;
  logic signed [63:0] r14, r16, r12, r40, r13;
  logic signed [23:0] ysat;
  logic [4:0] idx5;
  logic [15:0] t0, t1;
  logic [15:0] tmag;
  logic out_free;

  assign cfg_ready_o  = 1'b1;
  assign in_stall_o   = (state_q != rce_pkg::ST_IDLE);
  assign out_valid_o  = ov_q;
  assign sample_out_o = out_q;
  assign out_free     = !ov_q || !out_stall_i;

  assign rng_nx  = rce_pkg::xs32(rng_q);
  assign rng_nx2 = rce_pkg::xs32(rng_nx);
  assign cf      = step_q[2] ? lp_q : hp_q;
  assign coef    = cf[{step_q[1:0], 4'b0000} +: 16];
  assign hb      = {step_q[2], 2'b00};
  assign gdiff   = $signed({1'b0, goal_q}) - $signed({1'b0, lvl_q});
  assign half    = 17'(({1'b0, lvl_q} + 18'd65536) >> 1);

  assign r14 = (acc_q + 64'sd8192) >>> 14;
  assign r13 = r14;
  assign r12 = (acc_q + 64'sd2048) >>> 12;
  assign r16 = (acc_q + 64'sd32768) >>> 16;
  assign r40 = (acc_q + (64'sd1 <<< 39)) >>> 40;
  assign idx5 = acc_q[29:25];
  assign t0 = rce_pkg::tanh_lut({1'b0, idx5});
  assign t1 = rce_pkg::tanh_lut(6'({1'b0, idx5} + 6'd1));
  assign tmag = 16'(base_q + r13[15:0]);

  always_comb begin
    if (r14 > 64'sd8388607) begin
      ysat = 24'sd8388607;
    end else if (r14 < -64'sd8388608) begin
      ysat = -24'sd8388608;
    end else begin
      ysat = r14[23:0];
    end
  end

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    clr_acc = 1'b1;
    if (step_q <= rce_pkg::STEP_LP_LAST) begin
      op_b    = {{2{coef[15]}}, coef};
      clr_acc = (step_q[1:0] == 2'd0);
      case (step_q[1:0])
        2'd0: op_a = 42'(x_q) + 42'(hist_q[hb + 3'd1]);
        2'd1: op_a = 42'(hist_q[hb]);
        2'd2: op_a = -42'(hist_q[hb + 3'd2]);
        default: op_a = -42'(hist_q[hb + 3'd3]);
      endcase
    end else begin
      case (step_q)
        rce_pkg::STEP_DRIVE: begin
          op_a = $signed({18'd0, mag_q});
          op_b = {2'b00, gain_q};
        end
        rce_pkg::STEP_INTERP: begin
          op_a = $signed({29'd0, diff_q});
          op_b = {4'b0000, frac_q};
        end
        rce_pkg::STEP_NORM: begin
          op_a = 42'(th_q);
          op_b = {2'b00, norm_q};
        end
        rce_pkg::STEP_GOAL: begin
          op_a = $signed({18'd0, draw_q});
          op_b = 18'd19661;
        end
        rce_pkg::STEP_GLIDE: begin
          op_a = 42'(gdiff);
          op_b = 18'd3932;
        end
        rce_pkg::STEP_GATE: begin
          op_a = 42'(c_q);
          op_b = {1'b0, lvl_q};
        end
        rce_pkg::STEP_NOISE: begin
          op_a = $signed({18'd0, rng_nx[31:8]}) - 42'sd8388608;
          op_b = {2'b00, noise_q};
        end
        rce_pkg::STEP_MIX: begin
          op_a = p1_q;
          op_b = {1'b0, half};
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end
  end

  always_comb begin
    if (b_q[0]) begin
      addend = (bit_q == rce_pkg::MUL_LAST) ? -a_q : a_q;
    end else begin
      addend = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rce_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rce_pkg::ST_LOAD;
        end
      end
      rce_pkg::ST_LOAD: state_d = rce_pkg::ST_MUL;
      rce_pkg::ST_MUL: begin
        if (bit_q == rce_pkg::MUL_LAST) begin
          state_d = rce_pkg::ST_POST;
        end
      end
      rce_pkg::ST_POST: begin
        if (step_q == rce_pkg::STEP_NORM) begin
          state_d = rce_pkg::ST_GATE;
        end else if (step_q == rce_pkg::STEP_MIX) begin
          state_d = rce_pkg::ST_DONE;
        end else begin
          state_d = rce_pkg::ST_LOAD;
        end
      end
      rce_pkg::ST_GATE: state_d = rce_pkg::ST_LOAD;
      rce_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = rce_pkg::ST_IDLE;
        end
      end
      default: state_d = rce_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rce_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q     <= 64'd16384;
      lp_q     <= 64'd16384;
      gain_q   <= 16'd4096;
      norm_q   <= 16'd5378;
      thr_q    <= '0;
      noise_q  <= '0;
      period_q <= 16'd960;
      rng_q    <= 32'd1;
      for (int i = 0; i < 8; i++) begin
        hist_q[i] <= '0;
      end
      lvl_q  <= 17'd65536;
      goal_q <= 17'd65536;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
      step_q <= '0;
      bit_q  <= '0;
      x_q    <= '0;
      mag_q  <= '0;
      neg_q  <= 1'b0;
      base_q <= '0;
      diff_q <= '0;
      frac_q <= '0;
      th_q   <= '0;
      c_q    <= '0;
      v_q    <= '0;
      p1_q   <= '0;
      draw_q <= '0;
      out_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          rce_pkg::REG_HP:     hp_q <= cfg_data_i;
          rce_pkg::REG_LP:     lp_q <= cfg_data_i;
          rce_pkg::REG_GAIN:   gain_q <= cfg_data_i[15:0];
          rce_pkg::REG_NORM:   norm_q <= cfg_data_i[15:0];
          rce_pkg::REG_THR:    thr_q <= cfg_data_i[24:0];
          rce_pkg::REG_NOISE:  noise_q <= cfg_data_i[15:0];
          rce_pkg::REG_PERIOD: period_q <= cfg_data_i[15:0];
          rce_pkg::REG_SEED:   rng_q <= (cfg_data_i[31:0] == 32'd0) ? 32'd1 : cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (state_q == rce_pkg::ST_DONE && out_free) begin
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        rce_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            x_q    <= 24'(signed'(sample_in_i));
            step_q <= '0;
            if (start_flag_i) begin
              for (int i = 0; i < 8; i++) begin
                hist_q[i] <= '0;
              end
              lvl_q  <= 17'd65536;
              goal_q <= 17'd65536;
              cnt_q  <= '0;
            end
          end
        end
        rce_pkg::ST_LOAD: begin
          a_q   <= 60'(op_a);
          b_q   <= op_b;
          bit_q <= '0;
          if (clr_acc) begin
            acc_q <= '0;
          end
          if (step_q == rce_pkg::STEP_NOISE) begin
            rng_q <= rng_nx;
          end
        end
        rce_pkg::ST_MUL: begin
          acc_q <= acc_q + 64'(addend);
          a_q   <= a_q <<< 1;
          b_q   <= b_q >> 1;
          bit_q <= bit_q + 5'd1;
        end
        rce_pkg::ST_POST: begin
          step_q <= step_q + 5'd1;
          case (step_q)
            rce_pkg::STEP_HP_LAST, rce_pkg::STEP_LP_LAST: begin
              hist_q[hb + 3'd1] <= hist_q[hb];
              hist_q[hb]        <= x_q;
              hist_q[hb + 3'd3] <= hist_q[hb + 3'd2];
              hist_q[hb + 3'd2] <= ysat;
              x_q   <= ysat;
              neg_q <= ysat[23];
              mag_q <= ysat[23] ? 24'(-ysat) : ysat;
            end
            rce_pkg::STEP_DRIVE: begin
              frac_q <= acc_q[24:11];
              if (|acc_q[63:30]) begin
                base_q <= 16'd32767;
                diff_q <= '0;
              end else begin
                base_q <= t0;
                diff_q <= 13'(t1 - t0);
              end
            end
            rce_pkg::STEP_INTERP: begin
              th_q <= neg_q ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
            end
            rce_pkg::STEP_NORM:  c_q <= r12[20:0];
            rce_pkg::STEP_GOAL:  goal_q <= {2'b00, acc_q[38:24]};
            rce_pkg::STEP_GLIDE: lvl_q <= 17'($signed({1'b0, lvl_q}) + r16[17:0]);
            rce_pkg::STEP_GATE:  v_q <= r16[25:0];
            rce_pkg::STEP_NOISE: p1_q <= acc_q[41:0];
            rce_pkg::STEP_MIX:   v_q <= v_q + r40[25:0];
            default: ;
          endcase
        end
        rce_pkg::ST_GATE: begin
          if (cnt_q == 16'd0) begin
            cnt_q <= period_q;
            if ({1'b0, rng_nx[31:8]} < thr_q) begin
              rng_q  <= rng_nx2;
              draw_q <= rng_nx2[31:8];
              step_q <= rce_pkg::STEP_GOAL;
            end else begin
              rng_q  <= rng_nx;
              goal_q <= 17'd65536;
              step_q <= rce_pkg::STEP_GLIDE;
            end
          end else begin
            cnt_q  <= cnt_q - 16'd1;
            step_q <= rce_pkg::STEP_GLIDE;
          end
        end
        rce_pkg::ST_DONE: begin
          if (out_free) begin
            if (v_q > 26'sd32767) begin
              out_q <= 16'h7fff;
            end else if (v_q < -26'sd32768) begin
              out_q <= 16'h8000;
            end else begin
              out_q <= v_q[15:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ design/rce_checker.sv @@
// ----------------------------------------------------------------------------
// rce_checker
// Port-level checks for the radio channel effect, bound to the top level.
// ----------------------------------------------------------------------------
module rce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] sample_out_o
);

  // A sample keeps the block busy after it enters.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o ##1 in_stall_o)
    else $error("block free too soon after an input transaction");

  // The block frees up only by placing a result in its output register.
  a_free_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("block became free without a result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(sample_out_o))
    else $error("output sample changed while stalled");

endmodule

bind radio_channel_effect rce_checker u_rce_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .sample_out_o (sample_out_o)
);

@@ test/radio_channel_effect_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_channel_effect_checker
// Watches the sample, result and register channels of the radio channel
// effect. It keeps its own copy of the filter, gate and generator state,
// predicts each output sample and compares it with what the block delivers.
// ----------------------------------------------------------------------------
module radio_channel_effect_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] sample_in_i,
  input  logic        start_flag_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] sample_out_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          error_count_o,
  output int          pending_count_o
);

  localparam int TanhSteps[33] = '{
    0, 8025, 15143, 20813, 24956, 27797, 29660, 30847, 31589, 32048, 32329,
    32500, 32606, 32670, 32708, 32732, 32746, 32755, 32760, 32763, 32765,
    32766, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
    32767, 32767
  };

  logic [63:0] hp_coefs, lp_coefs;
  logic [15:0] drive, drive_scale, noise_amp, reroll_period;
  logic [24:0] drop_thresh;
  logic [31:0] lfsr;
  longint      taps[8];
  longint      gate_lvl, gate_tgt;
  int unsigned reroll_count;
  logic [15:0] expected_samples[$];
  int          errors;
  int          pending;

  assign error_count_o   = errors;
  assign pending_count_o = pending;

  function automatic longint round_up_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_bits(longint v, int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint coef_at(logic [63:0] packed_c, int k);
    return longint'($signed(packed_c[16*k +: 16]));
  endfunction

  function automatic logic [23:0] next_draw();
    lfsr = lfsr ^ (lfsr << 13);
    lfsr = lfsr ^ (lfsr >> 17);
    lfsr = lfsr ^ (lfsr << 5);
    return lfsr[31:8];
  endfunction

  function automatic longint filter_section(longint x, logic [63:0] c, int base);
    longint acc, y;
    acc = coef_at(c, 0) * x + coef_at(c, 1) * taps[base] + coef_at(c, 0) * taps[base+1]
        - coef_at(c, 2) * taps[base+2] - coef_at(c, 3) * taps[base+3];
    y = clamp_bits(round_up_shift(acc, 14), 24);
    taps[base+1] = taps[base];
    taps[base]   = x;
    taps[base+3] = taps[base+2];
    taps[base+2] = y;
    return y;
  endfunction

  function automatic void clear_channel_state();
    for (int i = 0; i < 8; i++) taps[i] = 0;
    gate_lvl     = 65536;
    gate_tgt     = 65536;
    reroll_count = 0;
  endfunction

  function automatic logic [15:0] effect_sample(logic [15:0] s, logic start);
    longint y, mag, t, th, clipped, v;
    longint idx;
    logic [23:0] d;
    if (start) clear_channel_state();
    y = filter_section(longint'($signed(s)), hp_coefs, 0);
    y = filter_section(y, lp_coefs, 4);
    mag = (y < 0) ? -y : y;
    t = (mag * longint'(drive)) >>> 11;
    idx = t >>> 14;
    if (idx >= 32) begin
      th = 32767;
    end else begin
      th = TanhSteps[idx] +
           (((TanhSteps[idx+1] - TanhSteps[idx]) * (t & 16'h3FFF) + 8192) >>> 14);
    end
    if (y < 0) th = -th;
    clipped = round_up_shift(th * longint'(drive_scale), 12);
    if (reroll_count == 0) begin
      reroll_count = reroll_period;
      d = next_draw();
      if (longint'(d) < longint'(drop_thresh)) begin
        gate_tgt = (longint'(next_draw()) * 19661) >>> 24;
      end else begin
        gate_tgt = 65536;
      end
    end else begin
      reroll_count--;
    end
    gate_lvl = gate_lvl + round_up_shift((gate_tgt - gate_lvl) * 3932, 16);
    v = round_up_shift(clipped * gate_lvl, 16);
    d = next_draw();
    v += round_up_shift((longint'(d) - 8388608) * longint'(noise_amp) *
                        ((65536 + gate_lvl) >>> 1), 40);
    return 16'(clamp_bits(v, 16));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [15:0] want;
    if (!rst_ni) begin
      hp_coefs      = 64'd16384;
      lp_coefs      = 64'd16384;
      drive         = 16'd4096;
      drive_scale   = 16'd5378;
      drop_thresh   = '0;
      noise_amp     = '0;
      reroll_period = 16'd960;
      lfsr          = 32'd1;
      errors        = 0;
      expected_samples.delete();
      pending       = 0;
      clear_channel_state();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          rce_pkg::REG_HP:     hp_coefs      = cfg_data_i;
          rce_pkg::REG_LP:     lp_coefs      = cfg_data_i;
          rce_pkg::REG_GAIN:   drive         = cfg_data_i[15:0];
          rce_pkg::REG_NORM:   drive_scale   = cfg_data_i[15:0];
          rce_pkg::REG_THR:    drop_thresh   = cfg_data_i[24:0];
          rce_pkg::REG_NOISE:  noise_amp     = cfg_data_i[15:0];
          rce_pkg::REG_PERIOD: reroll_period = cfg_data_i[15:0];
          rce_pkg::REG_SEED:
            lfsr = (cfg_data_i[31:0] == '0) ? 32'd1 : cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample_out transaction, expected none, actual %0d",
                   $time, $signed(sample_out_i));
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (sample_out_i !== want) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, $signed(want), $signed(sample_out_i));
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_samples = {expected_samples, effect_sample(sample_in_i, start_flag_i)};
      end
      pending = expected_samples.size();
    end
  end

endmodule

@@ test/radio_channel_effect_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_channel_effect_test
// Drives directed and random audio samples and register settings into the
// radio channel effect, with bursty input, a stalling receiver and one long
// hold-off, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module radio_channel_effect_test;

  localparam int CycleLimit = 20_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] sample_in_i = '0;
  logic        start_flag_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] sample_out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  int          error_count, pending_count;

  int          samples_sent = 0;
  int          burst_left = 0;
  int          stall_mode = 0;
  bit          gaps_on = 1'b1;
  int          hold_cnt = 0;
  bit          hold_done = 1'b0;
  int          cycles = 0;

  radio_channel_effect dut (.*);

  radio_channel_effect_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .sample_in_i, .start_flag_i,
    .out_valid_i(out_valid_o), .out_stall_i, .sample_out_i(sample_out_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .error_count_o(error_count), .pending_count_o(pending_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else if (samples_sent >= 600 && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt  = 1500;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= ($urandom_range(0, 9) < 8);
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic [15:0] s, logic start);
    in_valid_i   <= 1'b1;
    sample_in_i  <= s;
    start_flag_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    samples_sent++;
    if (gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      burst_left = $urandom_range(0, 20);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_coef();
    if ($urandom_range(0, 1)) return 16'($signed($urandom_range(0, 32767)) - 16384);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 2047)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_config();
    write_reg(rce_pkg::REG_HP, {pick_coef(), pick_coef(), pick_coef(), pick_coef()});
    write_reg(rce_pkg::REG_LP, {pick_coef(), pick_coef(), pick_coef(), pick_coef()});
    write_reg(rce_pkg::REG_GAIN, 64'($urandom_range(1, 65535)));
    write_reg(rce_pkg::REG_NORM, 64'($urandom_range(1, 65535)));
    write_reg(rce_pkg::REG_THR, ($urandom_range(0, 3) == 0) ? 64'd16777216
                                                            : 64'($urandom_range(0, 16777215)));
    write_reg(rce_pkg::REG_NOISE, ($urandom_range(0, 2) == 0) ? 64'd0
                                                              : 64'($urandom_range(0, 65535)));
    write_reg(rce_pkg::REG_PERIOD, ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 65535))
                                                               : 64'($urandom_range(0, 12)));
    write_reg(rce_pkg::REG_SEED, 64'($urandom));
  endtask

  initial begin
    logic [15:0] edge_vals[6];
    edge_vals = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h4000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (edge_vals[i]) send_sample(edge_vals[i], 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    wait_idle();

    write_reg(rce_pkg::REG_HP, 64'h7FFF_7FFF_8000_8000);
    write_reg(rce_pkg::REG_LP, 64'h7FFF_7FFF_8000_8000);
    write_reg(rce_pkg::REG_GAIN, 64'd65535);
    write_reg(rce_pkg::REG_NORM, 64'd65535);
    write_reg(rce_pkg::REG_THR, 64'd16777216);
    write_reg(rce_pkg::REG_NOISE, 64'd65535);
    write_reg(rce_pkg::REG_PERIOD, 64'd0);
    write_reg(rce_pkg::REG_SEED, 64'd0);
    foreach (edge_vals[i]) send_sample(edge_vals[i], 1'b0);
    send_sample(16'h8000, 1'b1);
    wait_idle();

    write_reg(rce_pkg::REG_HP, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(rce_pkg::REG_LP, 64'h0000_0000_0000_4000);
    write_reg(rce_pkg::REG_GAIN, 64'd0);
    write_reg(rce_pkg::REG_NORM, 64'd1);
    write_reg(rce_pkg::REG_THR, 64'd0);
    write_reg(rce_pkg::REG_NOISE, 64'd0);
    write_reg(rce_pkg::REG_PERIOD, 64'd65535);
    write_reg(rce_pkg::REG_SEED, 64'hFFFF_FFFF);
    foreach (edge_vals[i]) send_sample(edge_vals[i], 1'b0);
    wait_idle();
    write_reg(rce_pkg::REG_GAIN, 64'd1);
    send_sample(16'h7FFF, 1'b0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      random_config();
      stall_mode = p % 3;
      gaps_on = (p % 4 != 1);
      for (int n = 0; n < 250; n++) begin
        send_sample(pick_sample(), $urandom_range(0, 31) == 0);
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ radio_channel_effect.f @@
design/rce_pkg.sv
design/radio_channel_effect.sv
design/rce_checker.sv
test/radio_channel_effect_checker.sv
test/radio_channel_effect_test.sv
